FILE: hw/rtl/two_chain_finality_tracker_top_macros.svh
// Assertion macros for the finality tracker top level.
`ifndef TWO_CHAIN_FINALITY_TRACKER_TOP_MACROS_SVH
`define TWO_CHAIN_FINALITY_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tct_pkg.sv
// Shared types, constants and helpers of the finality tracker.
package tct_pkg;

	localparam int WIN_DEPTH = 64;
	localparam int AW        = $clog2(WIN_DEPTH);
	localparam int CW        = AW + 1;
	localparam int NUM_W     = 32;
	localparam int ID_W      = 256;
	localparam int WORD_W    = 64;
	localparam logic [CW:0] DEPTH_W = (CW + 1)'(WIN_DEPTH);

	typedef enum logic [1:0] {
		CMD_GENESIS = 2'd0,
		CMD_ADVANCE = 2'd1,
		CMD_EXTENDS = 2'd2,
		CMD_PREVIEW = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CLAIM    = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_TREAD,
		S_TCAP,
		S_OUT
	} fsm_t;

	typedef struct packed {
		logic latch;
		logic eval;
		logic tcap;
		logic out_valid;
	} ctl_cmd_t;

	typedef struct packed {
		logic commit;
	} dp_stat_t;

	// Block number is the low 32 bits of the id with bytes reversed.
	function automatic logic [NUM_W-1:0] num_of_id(input logic [WORD_W-1:0] w0);
		return {w0[7:0], w0[15:8], w0[23:16], w0[31:24]};
	endfunction

endpackage

FILE: hw/rtl/tct_if.sv
// Request and result channel interfaces of the finality tracker.
interface tct_item_if
	import tct_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        cmd;
	logic [WORD_W-1:0] id_w0;
	logic [WORD_W-1:0] id_w1;
	logic [WORD_W-1:0] id_w2;
	logic [WORD_W-1:0] id_w3;
	logic [NUM_W-1:0]  block_time;
	logic [NUM_W-1:0]  qc_block_num;
	logic              qc_strong;

	modport source (output valid, cmd, id_w0, id_w1, id_w2, id_w3, block_time,
		qc_block_num, qc_strong, input ready);
	modport sink (input valid, cmd, id_w0, id_w1, id_w2, id_w3, block_time,
		qc_block_num, qc_strong, output ready);
endinterface

interface tct_result_if
	import tct_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [NUM_W-1:0] current_num;
	logic [NUM_W-1:0] last_final_num;
	logic [NUM_W-1:0] latest_qc_num;
	logic             latest_qc_is_strong;
	logic [NUM_W-1:0] last_final_time;
	logic [NUM_W-1:0] latest_qc_time;
	logic             extends_flag;
	logic [NUM_W-1:0] preview_last_final;

	modport source (output valid, status, current_num, last_final_num, latest_qc_num,
		latest_qc_is_strong, last_final_time, latest_qc_time, extends_flag,
		preview_last_final, input ready);
	modport sink (input valid, status, current_num, last_final_num, latest_qc_num,
		latest_qc_is_strong, last_final_time, latest_qc_time, extends_flag,
		preview_last_final, output ready);
endinterface

FILE: hw/rtl/two_chain_finality_tracker_top.sv
// Top level of the two-chain finality tracker.
// Usage:
//   blk carries one request (genesis, advance, extends query or preview) per
//   valid/ready handshake; res returns exactly one result per request, with
//   the status code and the core's numbers and timestamps after the request.
//   The block works on one request at a time: blk.ready is high only while
//   no request is in flight. After acceptance the rings are read and the
//   request is evaluated; when a genesis or a successful advance changes the
//   core, the two timestamps are then read back from the reference ring over
//   its two read ports before the result is presented on res.
//   When the receiver stalls, the result holds on res and no new request is
//   taken until it is accepted.
//   After reset the core is empty: every request but genesis returns status
//   claim error with all number fields zero. The rings need no clearing.
`include "two_chain_finality_tracker_top_macros.svh"

module two_chain_finality_tracker_top
	import tct_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	tct_item_if.sink   blk,
	tct_result_if.source res
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	tct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (blk.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.req_ready (blk.ready),
		.ctl       (ctl)
	);

	tct_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.ctl                 (ctl),
		.cmd                 (blk.cmd),
		.id_w0               (blk.id_w0),
		.id_w1               (blk.id_w1),
		.id_w2               (blk.id_w2),
		.id_w3               (blk.id_w3),
		.block_time          (blk.block_time),
		.qc_block_num        (blk.qc_block_num),
		.qc_strong           (blk.qc_strong),
		.stat                (stat),
		.status              (res.status),
		.current_num         (res.current_num),
		.last_final_num      (res.last_final_num),
		.latest_qc_num       (res.latest_qc_num),
		.latest_qc_is_strong (res.latest_qc_is_strong),
		.last_final_time     (res.last_final_time),
		.latest_qc_time      (res.latest_qc_time),
		.extends_flag        (res.extends_flag),
		.preview_last_final  (res.preview_last_final)
	);

	assign res.valid = ctl.out_valid;

	`TCT_ASSERT_NOW(a_one_in_flight, res.valid, !blk.ready, "request taken while result pending")
	`TCT_ASSERT_NEXT(a_no_early_result, blk.valid && blk.ready, !res.valid, "result too early")
	`TCT_ASSERT_NEXT(a_idle_after_take, res.valid && res.ready, blk.ready, "not idle after result")
	`TCT_ASSERT_NOW(a_answers_need_ok, res.valid && res.status != ST_OK,
		res.preview_last_final == '0 && !res.extends_flag, "answer with error status")

endmodule

FILE: hw/rtl/tct_ctrl.sv
// Sequencing state machine of the finality tracker.
module tct_ctrl
	import tct_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     res_ready,
	input  dp_stat_t stat,
	output logic     req_ready,
	output ctl_cmd_t ctl
);

	fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (req_valid) state_d = S_READ;
			S_READ:  state_d = S_EVAL;
			S_EVAL:  state_d = stat.commit ? S_TREAD : S_OUT;
			S_TREAD: state_d = S_TCAP;
			S_TCAP:  state_d = S_OUT;
			S_OUT:   if (res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready     = (state_q == S_IDLE);
		ctl.latch     = (state_q == S_IDLE) && req_valid;
		ctl.eval      = (state_q == S_EVAL);
		ctl.tcap      = (state_q == S_TCAP);
		ctl.out_valid = (state_q == S_OUT);
	end

endmodule

FILE: hw/rtl/tct_dp.sv
// Datapath of the finality tracker: core registers, link and reference rings.
module tct_dp
	import tct_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          ctl,
	input  logic [1:0]        cmd,
	input  logic [WORD_W-1:0] id_w0,
	input  logic [WORD_W-1:0] id_w1,
	input  logic [WORD_W-1:0] id_w2,
	input  logic [WORD_W-1:0] id_w3,
	input  logic [NUM_W-1:0]  block_time,
	input  logic [NUM_W-1:0]  qc_block_num,
	input  logic              qc_strong,
	output dp_stat_t          stat,
	output logic [1:0]        status,
	output logic [NUM_W-1:0]  current_num,
	output logic [NUM_W-1:0]  last_final_num,
	output logic [NUM_W-1:0]  latest_qc_num,
	output logic              latest_qc_is_strong,
	output logic [NUM_W-1:0]  last_final_time,
	output logic [NUM_W-1:0]  latest_qc_time,
	output logic              extends_flag,
	output logic [NUM_W-1:0]  preview_last_final
);

	// latched request
	cmd_t             cmd_q;
	logic [ID_W-1:0]  id_q;
	logic [NUM_W-1:0] bt_q;
	logic [NUM_W-1:0] qn_q;
	logic             qs_q;

	// core state
	logic [AW-1:0]    link_head_q, ref_head_q;
	logic [CW-1:0]    link_cnt_q, ref_cnt_q;
	logic [NUM_W-1:0] fs_q, cur_q, gt_q, lf_q, nt_q;
	logic             ns_q;
	logic [NUM_W-1:0] lft_q, lqt_q;

	// result
	status_t          status_q;
	logic             ext_q;
	logic [NUM_W-1:0] prev_q;

	// rings
	logic [NUM_W-1:0] link_tgt_mem [WIN_DEPTH];
	logic [ID_W-1:0]  ref_id_mem   [WIN_DEPTH];
	logic [NUM_W-1:0] ref_time_mem [WIN_DEPTH];
	logic [NUM_W-1:0] link_rd_q;
	logic [ID_W-1:0]  ref_id_rd_q;
	logic [NUM_W-1:0] time_a_q, time_b_q;

	logic [NUM_W-1:0] bn, lidx, ridx, new_lf, drop_refs, nt_rel;
	logic [CW-1:0]    drop_links;
	logic [AW-1:0]    link_raddr, ref_raddr, time_b_addr;
	logic             claim_ok, ext_ok, refs_over, link_full, ref_full, core_empty;
	logic             commit, is_gen;
	status_t          adv_st, eval_st;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q <= cmd_t'(cmd);
			id_q  <= {id_w3, id_w2, id_w1, id_w0};
			bt_q  <= block_time;
			qn_q  <= qc_block_num;
			qs_q  <= qc_strong;
		end
	end

	always_comb begin
		bn          = num_of_id(id_q[WORD_W-1:0]);
		core_empty  = (link_cnt_q == '0);
		lidx        = qn_q - fs_q;
		claim_ok    = !(qn_q < nt_q) && !(qn_q > cur_q) && !(qn_q < fs_q)
			&& !(qn_q == nt_q && ns_q && !qs_q)
			&& (lidx < {{(NUM_W-CW){1'b0}}, link_cnt_q});
		link_raddr  = link_head_q + lidx[AW-1:0];
		ridx        = bn - lf_q;
		ref_raddr   = ref_head_q + ridx[AW-1:0];
		ext_ok      = !(bn < lf_q) && (bn < cur_q)
			&& (ridx < {{(NUM_W-CW){1'b0}}, ref_cnt_q}) && (ref_id_rd_q == id_q);
		new_lf      = qs_q ? link_rd_q : lf_q;
		drop_links  = qs_q ? lidx[CW-1:0] : '0;
		drop_refs   = new_lf - lf_q;
		refs_over   = drop_refs > {{(NUM_W-CW){1'b0}}, ref_cnt_q};
		link_full   = ({1'b0, link_cnt_q} - {1'b0, drop_links} + (CW+1)'(1)) > DEPTH_W;
		ref_full    = ({1'b0, ref_cnt_q} - {1'b0, drop_refs[CW-1:0]} + (CW+1)'(1)) > DEPTH_W;
		nt_rel      = nt_q - lf_q;
		time_b_addr = ref_head_q + nt_rel[AW-1:0];
		is_gen      = (link_cnt_q == CW'(1)) && (fs_q == lf_q);
	end

	always_comb begin
		priority if (!claim_ok || cur_q == '1) adv_st = ST_CLAIM;
		else if (bn != cur_q)                  adv_st = ST_MISMATCH;
		else if (refs_over)                    adv_st = ST_CLAIM;
		else if (link_full || ref_full)        adv_st = ST_FULL;
		else                                   adv_st = ST_OK;
	end

	always_comb begin
		if (cmd_q == CMD_GENESIS) begin
			eval_st = ST_OK;
		end else if (core_empty) begin
			eval_st = ST_CLAIM;
		end else begin
			unique case (cmd_q)
				CMD_ADVANCE: eval_st = adv_st;
				CMD_PREVIEW: eval_st = claim_ok ? ST_OK : ST_CLAIM;
				default:     eval_st = ST_OK;
			endcase
		end
		commit = ctl.eval && ((cmd_q == CMD_GENESIS)
			|| (cmd_q == CMD_ADVANCE && !core_empty && adv_st == ST_OK));
		stat.commit = commit;
	end

	// ring reads, registered every cycle
	always_ff @(posedge clk) begin
		link_rd_q   <= link_tgt_mem[link_raddr];
		ref_id_rd_q <= ref_id_mem[ref_raddr];
		time_a_q    <= ref_time_mem[ref_head_q];
		time_b_q    <= ref_time_mem[time_b_addr];
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			if (cmd_q == CMD_GENESIS) begin
				link_tgt_mem[0] <= bn;
			end else begin
				link_tgt_mem[link_head_q + link_cnt_q[AW-1:0]] <= qn_q;
				ref_id_mem[ref_head_q + ref_cnt_q[AW-1:0]]     <= id_q;
				ref_time_mem[ref_head_q + ref_cnt_q[AW-1:0]]   <= bt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_head_q <= '0;
			ref_head_q  <= '0;
			link_cnt_q  <= '0;
			ref_cnt_q   <= '0;
			fs_q        <= '0;
			cur_q       <= '0;
			gt_q        <= '0;
			lf_q        <= '0;
			nt_q        <= '0;
			ns_q        <= 1'b0;
			lft_q       <= '0;
			lqt_q       <= '0;
			status_q    <= ST_OK;
			ext_q       <= 1'b0;
			prev_q      <= '0;
		end else begin
			if (ctl.eval) begin
				status_q <= eval_st;
				ext_q    <= (cmd_q == CMD_EXTENDS) && !core_empty && ext_ok;
				prev_q   <= (cmd_q == CMD_PREVIEW && !core_empty && claim_ok) ? new_lf : '0;
			end
			if (commit) begin
				if (cmd_q == CMD_GENESIS) begin
					link_head_q <= '0;
					link_cnt_q  <= CW'(1);
					ref_head_q  <= '0;
					ref_cnt_q   <= '0;
					fs_q        <= bn;
					cur_q       <= bn;
					gt_q        <= bt_q;
					lf_q        <= bn;
					nt_q        <= bn;
					ns_q        <= 1'b0;
				end else begin
					// drop consumed links and references, append the new ones
					link_head_q <= link_head_q + drop_links[AW-1:0];
					link_cnt_q  <= link_cnt_q - drop_links + CW'(1);
					ref_head_q  <= ref_head_q + drop_refs[AW-1:0];
					ref_cnt_q   <= ref_cnt_q - drop_refs[CW-1:0] + CW'(1);
					fs_q        <= qs_q ? qn_q : fs_q;
					cur_q       <= cur_q + NUM_W'(1);
					lf_q        <= new_lf;
					nt_q        <= qn_q;
					ns_q        <= qs_q;
				end
			end
			if (ctl.tcap) begin
				lft_q <= (ref_cnt_q != '0) ? time_a_q : '0;
				lqt_q <= (!(nt_q < lf_q) && nt_rel < {{(NUM_W-CW){1'b0}}, ref_cnt_q})
					? time_b_q : '0;
			end
		end
	end

	assign status              = status_q;
	assign current_num         = cur_q;
	assign last_final_num      = lf_q;
	assign latest_qc_num       = nt_q;
	assign latest_qc_is_strong = ns_q;
	assign last_final_time     = is_gen ? gt_q : lft_q;
	assign latest_qc_time      = is_gen ? gt_q : lqt_q;
	assign extends_flag        = ext_q;
	assign preview_last_final  = prev_q;

endmodule

FILE: sim/tb_two_chain_finality_tracker_top.sv
// Testbench of the finality tracker: directed table, then random sequences, vs a predictor.
module tb_two_chain_finality_tracker_top;
	import tct_pkg::*;

	localparam int RUN_ITEMS   = 1750;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		cmd_t        cmd;
		logic [255:0] id;
		logic [31:0] btime;
		logic [31:0] qc;
		logic        strong_claim;
	} request_t;

	typedef struct {
		status_t     status;
		logic [31:0] cur;
		logic [31:0] lf;
		logic [31:0] qcn;
		logic        qcs;
		logic [31:0] lf_time;
		logic [31:0] qc_time;
		logic        ext;
		logic [31:0] prev;
	} core_view_t;

	// how a table row pins its expectation
	typedef enum int {PIN_NONE, PIN_ALL, PIN_STATUS} pin_t;

	typedef struct {
		request_t   req;
		pin_t       pin;
		core_view_t view;
	} row_t;

	logic clk;
	logic arst_n;
	tct_item_if   blk_if();
	tct_result_if res_if();

	two_chain_finality_tracker_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.blk   (blk_if),
		.res   (res_if)
	);

	// predicted core
	logic [31:0]  lk_target[WIN_DEPTH];
	logic         lk_strong[WIN_DEPTH];
	int unsigned  lk_head, lk_count;
	logic [255:0] bref_id[WIN_DEPTH];
	logic [31:0]  bref_time[WIN_DEPTH];
	int unsigned  bref_head, bref_count;
	logic [31:0]  front_src, cur_num, gen_time;

	core_view_t pending_views[$];
	int         errors;
	int         cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] id_number(logic [63:0] w0);
		return {w0[7:0], w0[15:8], w0[23:16], w0[31:24]};
	endfunction

	function automatic logic [255:0] id_with_number(logic [31:0] n, logic [223:0] upper);
		return {upper, n[7:0], n[15:8], n[23:16], n[31:24]};
	endfunction

	function automatic logic [31:0] final_num();
		return lk_target[lk_head % WIN_DEPTH];
	endfunction

	function automatic logic [31:0] newest_num();
		return lk_target[(lk_head + lk_count - 1) % WIN_DEPTH];
	endfunction

	function automatic logic newest_strong();
		return lk_strong[(lk_head + lk_count - 1) % WIN_DEPTH];
	endfunction

	function automatic logic [31:0] stamp_of(logic [31:0] n);
		logic [31:0] idx;
		idx = n - final_num();
		if (n < final_num() || idx >= bref_count)
			return 32'd0;
		return bref_time[(bref_head + idx) % WIN_DEPTH];
	endfunction

	function automatic bit claim_ok(logic [31:0] q, logic s, output logic [31:0] new_lf,
			output logic [31:0] new_fs);
		logic [31:0] idx;
		new_lf = '0;
		new_fs = '0;
		if (q < newest_num() || q > cur_num || q < front_src)
			return 0;
		if (q == newest_num() && newest_strong() && !s)
			return 0;
		idx = q - front_src;
		if (idx >= lk_count)
			return 0;
		if (s) begin
			new_lf = lk_target[(lk_head + idx) % WIN_DEPTH];
			new_fs = q;
		end else begin
			new_lf = final_num();
			new_fs = front_src;
		end
		return 1;
	endfunction

	function automatic status_t advance_core(request_t r);
		logic [31:0] new_lf, new_fs, drop_l, drop_r;
		int unsigned p;
		if (!claim_ok(r.qc, r.strong_claim, new_lf, new_fs) || cur_num == 32'hFFFF_FFFF)
			return ST_CLAIM;
		if (id_number(r.id[63:0]) != cur_num)
			return ST_MISMATCH;
		drop_l = new_fs - front_src;
		drop_r = new_lf - final_num();
		if (drop_r > bref_count)
			return ST_CLAIM;
		if (lk_count - drop_l + 1 > WIN_DEPTH || bref_count - drop_r + 1 > WIN_DEPTH)
			return ST_FULL;
		lk_head = (lk_head + drop_l) % WIN_DEPTH;
		lk_count -= drop_l;
		p = (lk_head + lk_count) % WIN_DEPTH;
		lk_target[p] = r.qc;
		lk_strong[p] = r.strong_claim;
		lk_count++;
		front_src = new_fs;
		bref_head = (bref_head + drop_r) % WIN_DEPTH;
		bref_count -= drop_r;
		p = (bref_head + bref_count) % WIN_DEPTH;
		bref_id[p] = r.id;
		bref_time[p] = r.btime;
		bref_count++;
		cur_num++;
		return ST_OK;
	endfunction

	function automatic logic query_extends(request_t r);
		logic [31:0] n;
		n = id_number(r.id[63:0]);
		if (n < final_num() || n >= cur_num || n - final_num() >= bref_count)
			return 1'b0;
		return bref_id[(bref_head + n - final_num()) % WIN_DEPTH] == r.id;
	endfunction

	function automatic core_view_t apply_request(request_t r);
		core_view_t v;
		logic [31:0] a, b;
		bit gen;
		v = '{status: ST_OK, default: '0};
		if (r.cmd == CMD_GENESIS) begin
			lk_head = 0;
			lk_count = 1;
			lk_target[0] = id_number(r.id[63:0]);
			lk_strong[0] = 1'b0;
			bref_head = 0;
			bref_count = 0;
			front_src = lk_target[0];
			cur_num = lk_target[0];
			gen_time = r.btime;
		end else if (lk_count == 0) begin
			v.status = ST_CLAIM;
		end else if (r.cmd == CMD_ADVANCE) begin
			v.status = advance_core(r);
		end else if (r.cmd == CMD_EXTENDS) begin
			v.ext = query_extends(r);
		end else if (claim_ok(r.qc, r.strong_claim, a, b)) begin
			v.prev = a;
		end else begin
			v.status = ST_CLAIM;
		end
		if (lk_count != 0) begin
			gen = lk_count == 1 && front_src == final_num();
			v.cur = cur_num;
			v.lf = final_num();
			v.qcn = newest_num();
			v.qcs = newest_strong();
			v.lf_time = gen ? gen_time : stamp_of(final_num());
			v.qc_time = gen ? gen_time : stamp_of(newest_num());
		end
		return v;
	endfunction

	// sender: bursts with random gaps
	int burst_left;

	task automatic send(request_t r);
		if (burst_left == 0) begin
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		blk_if.cmd          = r.cmd;
		blk_if.id_w0        = r.id[63:0];
		blk_if.id_w1        = r.id[127:64];
		blk_if.id_w2        = r.id[191:128];
		blk_if.id_w3        = r.id[255:192];
		blk_if.block_time   = r.btime;
		blk_if.qc_block_num = r.qc;
		blk_if.qc_strong    = r.strong_claim;
		blk_if.valid        = 1'b1;
		do
			@(posedge clk);
		while (!blk_if.ready);
		@(negedge clk);
		blk_if.valid = 1'b0;
	endtask

	task automatic issue(request_t r, pin_t pin, core_view_t pinned);
		core_view_t v;
		v = apply_request(r);
		if (pin == PIN_ALL)
			v = pinned;
		else if (pin == PIN_STATUS)
			v.status = pinned.status;
		pending_views.push_back(v);
		send(r);
	endtask

	// receiver stall pattern: one of four modes, redrawn when its random run ends
	int stall_mode, stall_left;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 60);
		end
		stall_left--;
		case (stall_mode)
			0: res_if.ready <= 1'b1;
			1: res_if.ready <= $urandom_range(0, 1);
			2: res_if.ready <= ($urandom_range(0, 7) == 0);
			default: res_if.ready <= (stall_left % 4) != 0;
		endcase
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		core_view_t w;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_views.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual status %0d",
					$time, res_if.status);
			end else begin
				w = pending_views.pop_front();
				check_field("status", w.status, res_if.status);
				check_field("current_num", w.cur, res_if.current_num);
				check_field("last_final_num", w.lf, res_if.last_final_num);
				check_field("latest_qc_num", w.qcn, res_if.latest_qc_num);
				check_field("latest_qc_is_strong", w.qcs, res_if.latest_qc_is_strong);
				check_field("last_final_time", w.lf_time, res_if.last_final_time);
				check_field("latest_qc_time", w.qc_time, res_if.latest_qc_time);
				check_field("extends_flag", w.ext, res_if.extends_flag);
				check_field("preview_last_final", w.prev, res_if.preview_last_final);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic request_t req(cmd_t c, logic [31:0] n, logic [31:0] t, logic [31:0] q,
			logic s);
		request_t r;
		r.cmd = c;
		r.id = id_with_number(n, '0);
		r.btime = t;
		r.qc = q;
		r.strong_claim = s;
		return r;
	endfunction

	function automatic core_view_t with_status(status_t s);
		core_view_t v;
		v = '{status: ST_OK, default: '0};
		v.status = s;
		return v;
	endfunction

	function automatic request_t random_request(int weak_bias);
		request_t r;
		logic [31:0] lo;
		int unsigned k, pick;
		r.cmd = CMD_ADVANCE;
		r.id = id_with_number(cur_num, {$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		r.btime = $urandom;
		lo = newest_num() > front_src ? newest_num() : front_src;
		r.qc = lo + $urandom_range(0, cur_num - lo);
		r.strong_claim = weak_bias == 3 ? 1'b0 : $urandom_range(0, 3) >= weak_bias;
		if (r.qc == newest_num() && newest_strong() && !r.strong_claim) begin
			if (weak_bias == 3 && cur_num > r.qc)
				r.qc++;
			else
				r.strong_claim = 1'b1;
		end
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
		end else if (pick < 78) begin
			r.cmd = CMD_EXTENDS;
			if (bref_count > 0 && $urandom_range(0, 2) != 0) begin
				k = $urandom_range(0, bref_count - 1);
				r.id = bref_id[(bref_head + k) % WIN_DEPTH];
				if ($urandom_range(0, 4) == 0)
					r.id[$urandom_range(32, 255)] ^= 1'b1;
			end
		end else if (pick < 88) begin
			r.cmd = CMD_PREVIEW;
			if ($urandom_range(0, 3) == 0)
				r.strong_claim = ~r.strong_claim;
		end else if (pick < 94) begin
			r.qc = $urandom_range(0, 1) ? cur_num + $urandom_range(1, 5) : $urandom;
		end else begin
			r.cmd = cmd_t'($urandom_range(1, 3));
			r.id = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom};
			r.qc = $urandom;
			r.strong_claim = $urandom_range(0, 1);
		end
		return r;
	endfunction

	row_t table_rows[$];

	initial begin
		core_view_t none;
		request_t r;
		int weak_bias, seq_left;
		none = '{status: ST_OK, default: '0};
		errors = 0;
		cycles = 0;
		burst_left = 0;
		stall_left = 0;
		lk_head = 0;
		lk_count = 0;
		bref_head = 0;
		bref_count = 0;
		front_src = '0;
		cur_num = '0;
		gen_time = '0;
		arst_n = 1'b0;
		blk_if.valid = 1'b0;
		blk_if.cmd = CMD_GENESIS;
		blk_if.id_w0 = '0;
		blk_if.id_w1 = '0;
		blk_if.id_w2 = '0;
		blk_if.id_w3 = '0;
		blk_if.block_time = '0;
		blk_if.qc_block_num = '0;
		blk_if.qc_strong = 1'b0;
		res_if.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty core rejects all but genesis
		table_rows.push_back('{req(CMD_ADVANCE, 0, 0, 0, 1), PIN_ALL, with_status(ST_CLAIM)});
		table_rows.push_back('{req(CMD_EXTENDS, 0, 0, 0, 0), PIN_ALL, with_status(ST_CLAIM)});
		table_rows.push_back('{req(CMD_PREVIEW, 0, 0, 0, 0), PIN_ALL, with_status(ST_CLAIM)});
		table_rows.push_back('{req(CMD_GENESIS, 100, 5, 0, 0), PIN_NONE, none});
		table_rows.push_back('{req(CMD_PREVIEW, 0, 0, 100, 0), PIN_NONE, none});
		table_rows.push_back('{req(CMD_ADVANCE, 100, 6, 100, 0), PIN_STATUS, with_status(ST_OK)});
		table_rows.push_back('{req(CMD_ADVANCE, 101, 7, 101, 1), PIN_STATUS, with_status(ST_OK)});
		table_rows.push_back('{req(CMD_ADVANCE, 102, 8, 99, 1), PIN_STATUS, with_status(ST_CLAIM)});
		table_rows.push_back('{req(CMD_ADVANCE, 102, 8, 103, 1), PIN_STATUS,
			with_status(ST_CLAIM)});
		table_rows.push_back('{req(CMD_ADVANCE, 50, 8, 102, 1), PIN_STATUS,
			with_status(ST_MISMATCH)});
		table_rows.push_back('{req(CMD_PREVIEW, 0, 0, 101, 0), PIN_STATUS, with_status(ST_CLAIM)});
		table_rows.push_back('{req(CMD_ADVANCE, 102, 9, 102, 1), PIN_STATUS, with_status(ST_OK)});
		table_rows.push_back('{req(CMD_PREVIEW, 0, 0, 103, 1), PIN_NONE, none});
		table_rows.push_back('{req(CMD_EXTENDS, 102, 0, 0, 0), PIN_NONE, none});
		table_rows.push_back('{req(CMD_EXTENDS, 101, 0, 0, 0), PIN_NONE, none});
		table_rows.push_back('{req(CMD_EXTENDS, 200, 0, 0, 0), PIN_NONE, none});
		table_rows.push_back('{req(CMD_GENESIS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0), PIN_NONE,
			none});
		table_rows.push_back('{req(CMD_ADVANCE, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1), PIN_STATUS,
			with_status(ST_CLAIM)});
		table_rows.push_back('{req(CMD_PREVIEW, 0, 0, 32'hFFFF_FFFF, 1), PIN_NONE, none});
		table_rows.push_back('{req(CMD_GENESIS, 0, 0, 0, 0), PIN_NONE, none});
		table_rows.push_back('{req(CMD_ADVANCE, 0, 32'hFFFF_FFFF, 0, 1), PIN_STATUS,
			with_status(ST_OK)});
		table_rows.push_back('{req(CMD_ADVANCE, 1, 3, 0, 0), PIN_STATUS, with_status(ST_CLAIM)});
		foreach (table_rows[i])
			issue(table_rows[i].req, table_rows[i].pin, table_rows[i].view);

		seq_left = 0;
		weak_bias = 0;
		for (int n = 0; n < RUN_ITEMS; n++) begin
			if (n == RUN_ITEMS / 2) begin
				while (pending_views.size() != 0)
					@(posedge clk);
				@(negedge clk);
			end
			if (seq_left == 0) begin
				seq_left = $urandom_range(40, 160);
				weak_bias = $urandom_range(0, 3);
				r.cmd = CMD_GENESIS;
				case ($urandom_range(0, 3))
					0: r.id = id_with_number(32'hFFFF_FFFF - $urandom_range(0, 80), '0);
					1: r.id = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom};
					default: r.id = id_with_number($urandom_range(0, 1000),
						{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
				endcase
				r.btime = $urandom;
				r.qc = $urandom;
				r.strong_claim = $urandom_range(0, 1);
			end else begin
				r = random_request(weak_bias);
			end
			seq_left--;
			issue(r, PIN_NONE, none);
		end

		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
